// ===== rtl/sbq_pkg.sv =====
// shared constants and types for the stereo biquad low-pass block
// sample, coefficient and accumulator widths, register indexes, coefficient bundle
// no dependencies
package sbq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  // past outputs carry 8 extra fraction bits
  localparam int YFRAC_BITS  = 8;
  localparam int Y_BITS      = SAMPLE_BITS + YFRAC_BITS;
  localparam int FRAC_BITS   = COEF_BITS - 2;
  // four product terms, the largest COEF_BITS + Y_BITS + 1 wide, plus headroom
  localparam int ACC_BITS    = COEF_BITS + Y_BITS + 3;
  localparam int INDEX_BITS  = 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [Y_BITS-1:0]      ysample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  typedef struct packed {
    coef_t feed_outer;
    coef_t feed_middle;
    coef_t fb_first;
    coef_t fb_second;
  } coef_set_t;

  localparam logic [INDEX_BITS-1:0] REG_FEED_OUTER  = INDEX_BITS'(0);
  localparam logic [INDEX_BITS-1:0] REG_FEED_MIDDLE = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] REG_FB_FIRST    = INDEX_BITS'(2);
  localparam logic [INDEX_BITS-1:0] REG_FB_SECOND   = INDEX_BITS'(3);

endpackage

// ===== rtl/sbq_channel.sv =====
// one channel of the direct form 1 biquad: products, sum, rounding, saturation
// holds the channel's input and output history; uses sbq_pkg
module sbq_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  sbq_pkg::sample_t     x,
  input  sbq_pkg::coef_set_t   coef,
  output sbq_pkg::sample_t     y
);

  sbq_pkg::sample_t  x1;
  sbq_pkg::sample_t  x2;
  sbq_pkg::ysample_t y1;
  sbq_pkg::ysample_t y2;

  logic signed [sbq_pkg::SAMPLE_BITS:0]                        ff_sum;
  logic signed [sbq_pkg::COEF_BITS+sbq_pkg::SAMPLE_BITS:0]     p_outer;
  logic signed [sbq_pkg::COEF_BITS+sbq_pkg::SAMPLE_BITS-1:0]   p_middle;
  logic signed [sbq_pkg::COEF_BITS+sbq_pkg::Y_BITS-1:0]        p_fb1;
  logic signed [sbq_pkg::COEF_BITS+sbq_pkg::Y_BITS-1:0]        p_fb2;
  sbq_pkg::acc_t                                               acc;
  sbq_pkg::acc_t                                               rnd;
  sbq_pkg::acc_t                                               y_max;
  sbq_pkg::acc_t                                               y_min;
  sbq_pkg::ysample_t                                           y8;
  logic signed [sbq_pkg::Y_BITS:0]                             y_half;
  logic signed [sbq_pkg::Y_BITS:0]                             y_int;

  // outer gain is shared by the current and two-back inputs
  assign ff_sum   = {x[sbq_pkg::SAMPLE_BITS-1], x} + {x2[sbq_pkg::SAMPLE_BITS-1], x2};
  assign p_outer  = coef.feed_outer * ff_sum;
  assign p_middle = coef.feed_middle * x1;
  assign p_fb1    = coef.fb_first * y1;
  assign p_fb2    = coef.fb_second * y2;

  assign acc = (sbq_pkg::acc_t'(p_outer) <<< sbq_pkg::YFRAC_BITS)
             + (sbq_pkg::acc_t'(p_middle) <<< sbq_pkg::YFRAC_BITS)
             - sbq_pkg::acc_t'(p_fb1)
             - sbq_pkg::acc_t'(p_fb2);

  // round half up to 8 fraction bits
  assign rnd = (acc + (sbq_pkg::acc_t'(1) <<< (sbq_pkg::FRAC_BITS - 1))) >>> sbq_pkg::FRAC_BITS;

  assign y_max = $signed({{(sbq_pkg::ACC_BITS-sbq_pkg::Y_BITS+1){1'b0}},
                          {(sbq_pkg::Y_BITS-1){1'b1}}});
  assign y_min = $signed({{(sbq_pkg::ACC_BITS-sbq_pkg::Y_BITS+1){1'b1}},
                          {(sbq_pkg::Y_BITS-1){1'b0}}});

  always_comb begin
    if (rnd > y_max) begin
      y8 = y_max[sbq_pkg::Y_BITS-1:0];
    end else if (rnd < y_min) begin
      y8 = y_min[sbq_pkg::Y_BITS-1:0];
    end else begin
      y8 = rnd[sbq_pkg::Y_BITS-1:0];
    end
  end

  // integer output: round half up, then clamp to the sample range
  assign y_half = {y8[sbq_pkg::Y_BITS-1], y8}
                + (sbq_pkg::Y_BITS+1)'(1 << (sbq_pkg::YFRAC_BITS - 1));
  assign y_int  = y_half >>> sbq_pkg::YFRAC_BITS;

  always_comb begin
    if (y_int[sbq_pkg::SAMPLE_BITS] != y_int[sbq_pkg::SAMPLE_BITS-1]) begin
      y = y_int[sbq_pkg::SAMPLE_BITS] ? {1'b1, {(sbq_pkg::SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(sbq_pkg::SAMPLE_BITS-1){1'b1}}};
    end else begin
      y = y_int[sbq_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (en) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= y8;
    end
  end

endmodule

// ===== rtl/stereo_biquad_lowpass.sv =====
// top level of the stereo two-pole low-pass filter in direct form 1
// input stage, coefficient registers, two sbq_channel instances, result register
// uses sbq_pkg and sbq_channel
//
// usage
//   s_* stream: one stereo frame per transfer, tdata = left, right (24 bits each)
//   m_* stream: one filtered frame per accepted frame, same packing
//   cfg port: coefficient writes, index 0..3, other indexes are dropped;
//     always ready, write only while no frame is in flight
// path: an accepted frame passes from the input register to the result register,
//   where m_tvalid rises; it moves on when the result register is free or emptying
// throughput: one frame per cycle while the output is not stalled; the whole filter
//   step of both channels (four products per channel, sum, rounding, saturation)
//   is combinational between the input register and the result register and also
//   closes the feedback through the one-back output
// stall: while m_tready is low the result register holds its frame and the
//   input register can still take one more frame; then s_tready drops
// reset: histories and coefficients clear to zero, both stages empty
module stereo_biquad_lowpass (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [2*sbq_pkg::SAMPLE_BITS-1:0] s_tdata,   // left_sample, right_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*sbq_pkg::SAMPLE_BITS-1:0] m_tdata,   // left_filtered, right_filtered
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbq_pkg::INDEX_BITS-1:0]    cfg_index,
  input  logic [sbq_pkg::COEF_BITS-1:0]     cfg_data
);

  sbq_pkg::coef_set_t coef;

  logic               in_valid;
  sbq_pkg::sample_t   in_left;
  sbq_pkg::sample_t   in_right;
  logic               advance;
  logic               fire;
  sbq_pkg::sample_t   left_y;
  sbq_pkg::sample_t   right_y;
  sbq_pkg::sample_t   res_left;
  sbq_pkg::sample_t   res_right;

  // coefficient writes, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbq_pkg::REG_FEED_OUTER:  coef.feed_outer  <= cfg_data;
        sbq_pkg::REG_FEED_MIDDLE: coef.feed_middle <= cfg_data;
        sbq_pkg::REG_FB_FIRST:    coef.fb_first    <= cfg_data;
        sbq_pkg::REG_FB_SECOND:   coef.fb_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the compute step moves on whenever the result register is free or emptying
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_left  <= s_tdata[sbq_pkg::SAMPLE_BITS-1:0];
      in_right <= s_tdata[2*sbq_pkg::SAMPLE_BITS-1:sbq_pkg::SAMPLE_BITS];
    end
  end

  sbq_channel u_left (
    .clk  (clk),
    .rst  (rst),
    .en   (fire),
    .x    (in_left),
    .coef (coef),
    .y    (left_y)
  );

  sbq_channel u_right (
    .clk  (clk),
    .rst  (rst),
    .en   (fire),
    .x    (in_right),
    .coef (coef),
    .y    (right_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_left  <= left_y;
      res_right <= right_y;
    end
  end

  assign m_tdata = {res_right, res_left};

  // an empty input stage never refuses a frame
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

  // a waiting frame is neither lost nor altered while the output is stalled
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_left) && $stable(in_right)))
    else $error("held input frame changed");

  // every step of the filter lands in the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("filter step produced no result");

  // a result only appears behind a frame that was in the input stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result without a frame");

endmodule

// ===== test/stereo_biquad_lowpass_tb.sv =====
// self-checking testbench for the stereo two-pole low-pass filter
// checks every filtered frame against a fixed-point predictor of both channels or a given expected frame
// depends on sbq_pkg and stereo_biquad_lowpass
`timescale 1ns / 1ps

module stereo_biquad_lowpass_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 100_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_FRAMES = 65;

  // indexes the block must drop
  localparam logic [sbq_pkg::INDEX_BITS-1:0] REG_SPARE     = sbq_pkg::INDEX_BITS'(4);
  localparam logic [sbq_pkg::INDEX_BITS-1:0] REG_INDEX_TOP = '1;

  // slots of the gain bank
  localparam logic [1:0] SLOT_OUTER  = sbq_pkg::REG_FEED_OUTER[1:0];
  localparam logic [1:0] SLOT_MIDDLE = sbq_pkg::REG_FEED_MIDDLE[1:0];
  localparam logic [1:0] SLOT_FB1    = sbq_pkg::REG_FB_FIRST[1:0];
  localparam logic [1:0] SLOT_FB2    = sbq_pkg::REG_FB_SECOND[1:0];

  localparam sbq_pkg::sample_t SAMPLE_MOST  = {1'b0, {(sbq_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam sbq_pkg::sample_t SAMPLE_LEAST = {1'b1, {(sbq_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam sbq_pkg::coef_t   COEF_MOST    = {1'b0, {(sbq_pkg::COEF_BITS-1){1'b1}}};
  localparam sbq_pkg::coef_t   COEF_LEAST   = {1'b1, {(sbq_pkg::COEF_BITS-1){1'b0}}};
  localparam int               ONE_Q30      = 1 << sbq_pkg::FRAC_BITS;

  typedef logic signed [127:0] wide_t;

  localparam wide_t HALF_COEF_LSB = wide_t'(1) <<< (sbq_pkg::FRAC_BITS - 1);
  localparam wide_t HALF_Y_LSB    = wide_t'(1) <<< (sbq_pkg::YFRAC_BITS - 1);

  typedef struct packed {
    sbq_pkg::sample_t  x1;
    sbq_pkg::sample_t  x2;
    sbq_pkg::ysample_t y1;
    sbq_pkg::ysample_t y2;
  } chan_hist_t;

  typedef struct packed {
    sbq_pkg::sample_t right;
    sbq_pkg::sample_t left;
  } frame_t;

  typedef enum logic {ROW_COEF, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [sbq_pkg::INDEX_BITS-1:0] index;
    sbq_pkg::coef_t                 value;
    frame_t                         frame;
    bit                             typed;
    frame_t                         want;
  } plan_row_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [2*sbq_pkg::SAMPLE_BITS-1:0] s_tdata;   // left_sample, right_sample
  logic                              m_tvalid;
  logic                              m_tready;
  logic [2*sbq_pkg::SAMPLE_BITS-1:0] m_tdata;   // left_filtered, right_filtered
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [sbq_pkg::INDEX_BITS-1:0]    cfg_index;
  logic [sbq_pkg::COEF_BITS-1:0]     cfg_data;

  sbq_pkg::coef_t gain_bank [4];
  chan_hist_t     left_hist;
  chan_hist_t     right_hist;
  frame_t         pending_frames [$];
  plan_row_t      plan [$];
  int             mismatches;
  int             frames_in;
  int             frames_out;

  stereo_biquad_lowpass dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("stereo_biquad_lowpass test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic wide_t saturate(input wide_t v, input int bits);
    wide_t top;
    top = (wide_t'(1) <<< (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // one channel step: exact sum, round to 8 fraction bits, clamp, shift history,
  // then round to an integer sample and clamp again
  function automatic sbq_pkg::sample_t filter_channel(inout chan_hist_t hist,
                                                      input sbq_pkg::sample_t x);
    wide_t acc;
    acc = $signed(gain_bank[SLOT_OUTER]) * $signed(x) * 256
        + $signed(gain_bank[SLOT_MIDDLE]) * $signed(hist.x1) * 256
        + $signed(gain_bank[SLOT_OUTER]) * $signed(hist.x2) * 256
        - $signed(gain_bank[SLOT_FB1]) * $signed(hist.y1)
        - $signed(gain_bank[SLOT_FB2]) * $signed(hist.y2);
    acc = saturate((acc + HALF_COEF_LSB) >>> sbq_pkg::FRAC_BITS, sbq_pkg::Y_BITS);
    hist.x2 = hist.x1;
    hist.x1 = x;
    hist.y2 = hist.y1;
    hist.y1 = acc[sbq_pkg::Y_BITS-1:0];
    acc = saturate((acc + HALF_Y_LSB) >>> sbq_pkg::YFRAC_BITS, sbq_pkg::SAMPLE_BITS);
    return acc[sbq_pkg::SAMPLE_BITS-1:0];
  endfunction

  function automatic sbq_pkg::sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MOST;
      1:       return SAMPLE_LEAST;
      2, 3:    return sbq_pkg::sample_t'(int'($urandom_range(0, 1023)) - 512);
      default: return sbq_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic sbq_pkg::coef_t extreme_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_MOST;
      1:       return COEF_LEAST;
      2:       return '0;
      default: return sbq_pkg::coef_t'(ONE_Q30);
    endcase
  endfunction

  task automatic plan_coef(input logic [sbq_pkg::INDEX_BITS-1:0] idx,
                           input sbq_pkg::coef_t val);
    plan_row_t row;
    row.kind  = ROW_COEF;
    row.index = idx;
    row.value = val;
    row.frame = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endtask

  task automatic plan_frame(input sbq_pkg::sample_t l, input sbq_pkg::sample_t r,
                            input bit typed,
                            input sbq_pkg::sample_t wl, input sbq_pkg::sample_t wr);
    plan_row_t row;
    row.kind  = ROW_FRAME;
    row.index = '0;
    row.value = '0;
    row.frame = '{right: r, left: l};
    row.typed = typed;
    row.want  = '{right: wr, left: wl};
    plan.push_back(row);
  endtask

  // valid stays high after the transfer so the next call can keep it up
  task automatic write_coef(input logic [sbq_pkg::INDEX_BITS-1:0] idx,
                            input sbq_pkg::coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= sbq_pkg::REG_FB_SECOND) gain_bank[idx[1:0]] = val;
  endtask

  task automatic send_frame(input frame_t f, input bit typed, input frame_t want);
    frame_t predicted;
    while (!(frames_in >= 250 && frames_in < 330) && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted.left  = filter_channel(left_hist, f.left);
    predicted.right = filter_channel(right_hist, f.right);
    pending_frames.push_back(typed ? want : predicted);
    frames_in++;
  endtask

  // coefficient writes only with nothing in flight
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure, one long hold-off, a stretch always ready
  initial begin : result_side
    int     hold_left;
    bit     held;
    frame_t want;
    hold_left = 0;
    held      = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        frames_out++;
        if (pending_frames.size() == 0) begin
          report_mismatch($sformatf("frame %h with none expected", m_tdata));
        end else begin
          want = pending_frames.pop_front();
          if (m_tdata[sbq_pkg::SAMPLE_BITS-1:0] !== want.left)
            report_mismatch($sformatf("left_filtered %h, expected %h",
                                      m_tdata[sbq_pkg::SAMPLE_BITS-1:0], want.left));
          if (m_tdata[2*sbq_pkg::SAMPLE_BITS-1:sbq_pkg::SAMPLE_BITS] !== want.right)
            report_mismatch($sformatf("right_filtered %h, expected %h",
                                      m_tdata[2*sbq_pkg::SAMPLE_BITS-1:sbq_pkg::SAMPLE_BITS],
                                      want.right));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (frames_out == 120 && !held) begin
        // long hold-off while the sender keeps going, fills both stages
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (frames_out >= 250 && frames_out < 330) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin : stimulus
    sbq_pkg::coef_t outer, middle, fb1, fb2;
    int             pole_sq;
    frame_t         f;
    mismatches = 0;
    frames_in  = 0;
    frames_out = 0;
    foreach (gain_bank[i]) gain_bank[i] = '0;
    left_hist  = '0;
    right_hist = '0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // all gains zero after reset, so silence whatever goes in
    plan_frame(SAMPLE_MOST, SAMPLE_LEAST, 1'b1, '0, '0);
    plan_frame(SAMPLE_LEAST, SAMPLE_MOST, 1'b1, '0, '0);
    plan_frame('0, sbq_pkg::sample_t'(-1), 1'b1, '0, '0);
    plan_frame(sbq_pkg::sample_t'(-1), '0, 1'b1, '0, '0);
    // unity outer gain: y = x0 + x2, clamping at both ends
    plan_coef(sbq_pkg::REG_FEED_OUTER, sbq_pkg::coef_t'(ONE_Q30));
    plan_frame(SAMPLE_MOST, SAMPLE_LEAST, 1'b1, SAMPLE_MOST, SAMPLE_LEAST);
    plan_frame(SAMPLE_MOST, SAMPLE_LEAST, 1'b1, SAMPLE_MOST - 1, SAMPLE_LEAST);
    plan_frame(SAMPLE_MOST, SAMPLE_MOST, 1'b1, SAMPLE_MOST, sbq_pkg::sample_t'(-1));
    // 1/256 gain: output rounding half up, including a tie on the negative side
    plan_coef(sbq_pkg::REG_FEED_OUTER, sbq_pkg::coef_t'(1 << (sbq_pkg::FRAC_BITS - 8)));
    plan_frame(sbq_pkg::sample_t'(128), sbq_pkg::sample_t'(-128), 1'b0, '0, '0);
    plan_frame(sbq_pkg::sample_t'(-128), sbq_pkg::sample_t'(128), 1'b0, '0, '0);
    plan_frame(sbq_pkg::sample_t'(384), sbq_pkg::sample_t'(-384), 1'b0, '0, '0);
    // feedback in play
    plan_coef(sbq_pkg::REG_FEED_MIDDLE, sbq_pkg::coef_t'(ONE_Q30));
    plan_coef(sbq_pkg::REG_FB_FIRST, -sbq_pkg::coef_t'(ONE_Q30));
    plan_coef(sbq_pkg::REG_FB_SECOND, sbq_pkg::coef_t'(ONE_Q30 / 2));
    plan_frame(sbq_pkg::sample_t'(1000), sbq_pkg::sample_t'(-1000), 1'b0, '0, '0);
    plan_frame('0, '0, 1'b0, '0, '0);
    plan_frame(SAMPLE_MOST, SAMPLE_LEAST, 1'b0, '0, '0);
    // writes to unused indexes must leave the gains alone
    plan_coef(REG_SPARE, '1);
    plan_coef(REG_INDEX_TOP, COEF_LEAST);
    plan_frame('0, '0, 1'b0, '0, '0);
    // extreme gains, the accumulator at its widest
    plan_coef(sbq_pkg::REG_FEED_OUTER, COEF_LEAST);
    plan_coef(sbq_pkg::REG_FEED_MIDDLE, COEF_MOST);
    plan_coef(sbq_pkg::REG_FB_FIRST, COEF_LEAST);
    plan_coef(sbq_pkg::REG_FB_SECOND, COEF_MOST);
    plan_frame(SAMPLE_MOST, SAMPLE_LEAST, 1'b0, '0, '0);
    plan_frame(SAMPLE_LEAST, SAMPLE_MOST, 1'b0, '0, '0);
    plan_frame(sbq_pkg::sample_t'(-1), sbq_pkg::sample_t'(1), 1'b0, '0, '0);
    plan_frame('0, '0, 1'b0, '0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COEF) begin
        wait_drained();
        write_coef(plan[i].index, plan[i].value);
      end else begin
        cfg_valid <= 1'b0;
        send_frame(plan[i].frame, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase % 3)
        0: begin
          // realistic low-pass: small feed gains, stable pole pair
          outer   = sbq_pkg::coef_t'($urandom_range(1 << 16, 1 << 26));
          middle  = outer <<< 1;
          pole_sq = $urandom_range(ONE_Q30 / 10 * 6, ONE_Q30 / 100 * 95);
          fb2     = sbq_pkg::coef_t'(pole_sq);
          fb1     = sbq_pkg::coef_t'(-(ONE_Q30 + int'($urandom_range(0, pole_sq - 1))));
        end
        1: begin
          outer  = sbq_pkg::coef_t'($urandom);
          middle = sbq_pkg::coef_t'($urandom);
          fb1    = sbq_pkg::coef_t'($urandom);
          fb2    = sbq_pkg::coef_t'($urandom);
        end
        default: begin
          outer  = extreme_coef();
          middle = extreme_coef();
          fb1    = extreme_coef();
          fb2    = extreme_coef();
        end
      endcase
      write_coef(sbq_pkg::REG_FEED_OUTER, outer);
      write_coef(sbq_pkg::REG_FEED_MIDDLE, middle);
      write_coef(sbq_pkg::REG_FB_FIRST, fb1);
      write_coef(sbq_pkg::REG_FB_SECOND, fb2);
      if ($urandom_range(0, 1) == 1)
        write_coef(sbq_pkg::INDEX_BITS'($urandom_range(int'(REG_SPARE),
                                                       int'(REG_INDEX_TOP))),
                   sbq_pkg::coef_t'($urandom));
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        f.left  = random_sample();
        f.right = random_sample();
        send_frame(f, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("stereo_biquad_lowpass test passed");
    end else begin
      $display("stereo_biquad_lowpass test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbq_pkg.sv
rtl/sbq_channel.sv
rtl/stereo_biquad_lowpass.sv
test/stereo_biquad_lowpass_tb.sv
